>>> rtl/rgbr_pkg.sv
// ----------------------------------------------------------------------------
// rgbr_pkg
// Shared widths, register codes and the job record passed from the
// classification front end to the averaging back end of the row resampler.
// ----------------------------------------------------------------------------
package rgbr_pkg;

  // default parameter values for the top level
  localparam int MAX_WIDTH_DEF = 4096;
  localparam int MAX_RATIO_DEF = 64;

  // field widths
  localparam int CFG_W     = 13;
  localparam int SUM_IN_W  = 24;
  localparam int CNT_IN_W  = 16;
  localparam int ACC_W     = 32;
  localparam int CNT_ACC_W = 24;
  localparam int CHAN_W    = 8;

  // repeat count of one job; holds the largest ratio the block supports (64)
  localparam int REPS_W = 7;

  // job queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // configuration register indexes
  localparam int CFG_IDX_W = 1;
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SOURCE_WIDTH = 1'b0,
    REG_TARGET_WIDTH = 1'b1
  } cfg_reg_t;

  // configuration as seen by the front end
  typedef struct packed {
    logic [CFG_W-1:0] source_width;
    logic [CFG_W-1:0] target_width;
  } cfg_t;

  // one averaging job: channel sums, sample count and how often to emit it
  typedef struct packed {
    logic signed [ACC_W-1:0] red;
    logic signed [ACC_W-1:0] green;
    logic signed [ACC_W-1:0] blue;
    logic [CNT_ACC_W-1:0]    count;
    logic [REPS_W-1:0]       reps;
  } job_t;

endpackage

>>> rtl/rgbr_front.sv
// ----------------------------------------------------------------------------
// rgbr_front
// Takes source pixels, runs the Bresenham error term and the column
// accumulators, and turns each finished column or repeated pixel into a job.
// ----------------------------------------------------------------------------
module rgbr_front #(
  parameter int MAX_WIDTH = rgbr_pkg::MAX_WIDTH_DEF,
  parameter int MAX_RATIO = rgbr_pkg::MAX_RATIO_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  rgbr_pkg::cfg_t                        cfg,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [rgbr_pkg::SUM_IN_W-1:0]  in_red,
  input  logic signed [rgbr_pkg::SUM_IN_W-1:0]  in_green,
  input  logic signed [rgbr_pkg::SUM_IN_W-1:0]  in_blue,
  input  logic [rgbr_pkg::CNT_IN_W-1:0]         in_count,
  input  logic                                  in_row_start,
  output rgbr_pkg::job_t                        job,
  output logic                                  push,
  input  logic                                  full
);
  import rgbr_pkg::*;

  localparam int WCAP = (MAX_WIDTH > (2**CFG_W - 1)) ? (2**CFG_W - 1) : MAX_WIDTH;
  localparam logic [CFG_W-1:0] WMAX = CFG_W'(WCAP);
  localparam int ERR_W = $clog2(WCAP + 1) + 4;
  localparam logic [REPS_W-1:0] RATIO_CAP = REPS_W'(MAX_RATIO);
  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  typedef enum logic [1:0] {
    F_IDLE = 2'b01,
    F_STEP = 2'b10
  } fstate_t;

  function automatic logic [CFG_W-1:0] eff_width(input logic [CFG_W-1:0] v);
    logic [CFG_W-1:0] r;
    if (v == '0) begin
      r = CFG_W'(1);
    end else if (v > WMAX) begin
      r = WMAX;
    end else begin
      r = v;
    end
    return r;
  endfunction

  function automatic logic signed [ACC_W-1:0] sat_acc(input logic signed [ACC_W:0] v);
    logic signed [ACC_W-1:0] r;
    if (v[ACC_W] != v[ACC_W-1]) begin
      r = v[ACC_W] ? ACC_MIN : ACC_MAX;
    end else begin
      r = v[ACC_W-1:0];
    end
    return r;
  endfunction

  fstate_t state;
  logic signed [ERR_W-1:0] err;
  logic signed [ACC_W-1:0] red_acc, green_acc, blue_acc;
  logic [CNT_ACC_W-1:0]    cnt_acc;
  logic signed [ACC_W-1:0] pix_red, pix_green, pix_blue;
  logic [CNT_ACC_W-1:0]    pix_count;
  logic [REPS_W-1:0]       reps;

  logic [CFG_W-1:0]        src_eff, tgt_eff;
  logic signed [ERR_W-1:0] src1, tgt1, src2, tgt2;
  logic                    shrink, accept;
  logic signed [ERR_W-1:0] err_start, err_shr;
  logic                    col_done;
  logic signed [ACC_W-1:0] red_base, green_base, blue_base;
  logic [CNT_ACC_W-1:0]    cnt_base;
  logic signed [ACC_W:0]   red_wide, green_wide, blue_wide;
  logic [CNT_ACC_W:0]      cnt_wide;
  logic signed [ACC_W-1:0] red_next, green_next, blue_next;
  logic [CNT_ACC_W-1:0]    cnt_next;
  logic                    step_done;

  // effective widths and the error increments
  always_comb begin
    src_eff = eff_width(cfg.source_width);
    tgt_eff = eff_width(cfg.target_width);
    src1    = $signed(ERR_W'(src_eff));
    tgt1    = $signed(ERR_W'(tgt_eff));
    src2    = $signed(ERR_W'({src_eff, 1'b0}));
    tgt2    = $signed(ERR_W'({tgt_eff, 1'b0}));
    shrink  = (tgt_eff <= src_eff);
  end

  assign in_ready = (state == F_IDLE) && !full;
  assign accept   = in_valid && in_ready;

  // row start reload and shrink step
  always_comb begin
    if (in_row_start) begin
      err_start  = shrink ? (src2 - tgt1) : (tgt2 - src1);
      red_base   = '0;
      green_base = '0;
      blue_base  = '0;
      cnt_base   = '0;
    end else begin
      err_start  = err;
      red_base   = red_acc;
      green_base = green_acc;
      blue_base  = blue_acc;
      cnt_base   = cnt_acc;
    end
    err_shr   = err_start - tgt2;
    col_done  = err_shr[ERR_W-1];
    red_wide   = (ACC_W+1)'(red_base) + (ACC_W+1)'(in_red);
    green_wide = (ACC_W+1)'(green_base) + (ACC_W+1)'(in_green);
    blue_wide  = (ACC_W+1)'(blue_base) + (ACC_W+1)'(in_blue);
    cnt_wide   = {1'b0, cnt_base} + (CNT_ACC_W+1)'(in_count);
    red_next   = sat_acc(red_wide);
    green_next = sat_acc(green_wide);
    blue_next  = sat_acc(blue_wide);
    cnt_next   = cnt_wide[CNT_ACC_W] ? '1 : cnt_wide[CNT_ACC_W-1:0];
  end

  // repeat loop finishes once the error term is negative and any due job can be pushed
  assign step_done = (state == F_STEP) && err[ERR_W-1] && ((reps == '0) || !full);

  // job handed to the queue
  always_comb begin
    job.red   = pix_red;
    job.green = pix_green;
    job.blue  = pix_blue;
    job.count = pix_count;
    job.reps  = reps;
    push      = 1'b0;
    if (state == F_IDLE) begin
      job.red   = red_next;
      job.green = green_next;
      job.blue  = blue_next;
      job.count = cnt_next;
      job.reps  = REPS_W'(1);
      push      = accept && shrink && col_done;
    end else begin
      push = step_done && (reps != '0);
    end
  end

  // error term, accumulators and repeat loop
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= F_IDLE;
      err       <= '0;
      red_acc   <= '0;
      green_acc <= '0;
      blue_acc  <= '0;
      cnt_acc   <= '0;
      reps      <= '0;
    end else begin
      unique case (state)
        F_IDLE: begin
          if (accept) begin
            if (shrink) begin
              if (col_done) begin
                err       <= err_shr + src2;
                red_acc   <= '0;
                green_acc <= '0;
                blue_acc  <= '0;
                cnt_acc   <= '0;
              end else begin
                err       <= err_shr;
                red_acc   <= red_next;
                green_acc <= green_next;
                blue_acc  <= blue_next;
                cnt_acc   <= cnt_next;
              end
            end else begin
              err       <= err_start;
              red_acc   <= '0;
              green_acc <= '0;
              blue_acc  <= '0;
              cnt_acc   <= '0;
              reps      <= '0;
              state     <= F_STEP;
            end
          end
        end
        F_STEP: begin
          if (!err[ERR_W-1]) begin
            err <= err - src2;
            if (reps != RATIO_CAP) begin
              reps <= reps + REPS_W'(1);
            end
          end else if (step_done) begin
            err   <= err + tgt2;
            state <= F_IDLE;
          end
        end
        default: state <= F_IDLE;
      endcase
    end
  end

  // pixel held for the repeat loop
  always_ff @(posedge clk) begin
    if (accept && !shrink) begin
      pix_red   <= ACC_W'(in_red);
      pix_green <= ACC_W'(in_green);
      pix_blue  <= ACC_W'(in_blue);
      pix_count <= CNT_ACC_W'(in_count);
    end
  end

endmodule

>>> rtl/rgbr_queue.sv
// ----------------------------------------------------------------------------
// rgbr_queue
// Short job queue that lets the front end and the back end stall on their own.
// ----------------------------------------------------------------------------
module rgbr_queue (
  input  logic           clk,
  input  logic           rst,
  input  rgbr_pkg::job_t wr_job,
  input  logic           push,
  output logic           full,
  output rgbr_pkg::job_t rd_job,
  input  logic           pop,
  output logic           empty
);
  import rgbr_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(QUEUE_DEPTH);
  localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(QUEUE_DEPTH - 1);

  job_t             slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] fill;

  assign full   = (fill == DEPTH_CNT);
  assign empty  = (fill == '0);
  assign rd_job = slots[rd_ptr];

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        fill <= fill + CNT_W'(1);
      end else if (pop && !push) begin
        fill <= fill - CNT_W'(1);
      end
    end
  end

  // job storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_job;
    end
  end

  // overrun and underrun checks
  assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("job written into a full queue");
  assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("job read from an empty queue");

endmodule

>>> rtl/rgbr_back.sv
// ----------------------------------------------------------------------------
// rgbr_back
// Divides each job's channel sums by its sample count one quotient bit per
// cycle, clamps to 0..255 and emits the pixel as often as the job asks.
// ----------------------------------------------------------------------------
module rgbr_back (
  input  logic                        clk,
  input  logic                        rst,
  input  rgbr_pkg::job_t              job,
  input  logic                        empty,
  output logic                        pop,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [rgbr_pkg::CHAN_W-1:0] out_red,
  output logic [rgbr_pkg::CHAN_W-1:0] out_green,
  output logic [rgbr_pkg::CHAN_W-1:0] out_blue,
  output logic                        out_empty,
  output logic                        out_last
);
  import rgbr_pkg::*;

  localparam int NCH   = 3;
  localparam int REM_W = ACC_W - 1;
  localparam int STP_W = $clog2(CHAN_W);
  localparam logic [STP_W-1:0] LAST_STEP = STP_W'(CHAN_W - 1);

  typedef enum logic [2:0] {
    B_IDLE = 3'b001,
    B_DIV  = 3'b010,
    B_EMIT = 3'b100
  } bstate_t;

  bstate_t state;
  logic [REM_W-1:0]  rem [NCH];
  logic [CHAN_W-1:0] quo [NCH];
  logic [NCH-1:0]    neg, sat;
  logic [REM_W-1:0]  dvs;
  logic [STP_W-1:0]  step;
  logic              is_empty;
  logic [REPS_W-1:0] reps_left;

  logic signed [ACC_W-1:0] sum_in [NCH];
  logic [CHAN_W-1:0]       chan_res [NCH];
  logic                    load_out;

  assign sum_in[0] = job.red;
  assign sum_in[1] = job.green;
  assign sum_in[2] = job.blue;

  assign pop      = (state == B_IDLE) && !empty;
  assign load_out = (state == B_EMIT) && (!out_valid || out_ready);

  // clamped channel values
  always_comb begin
    for (int c = 0; c < NCH; c++) begin
      if (is_empty || neg[c]) begin
        chan_res[c] = '0;
      end else if (sat[c]) begin
        chan_res[c] = '1;
      end else begin
        chan_res[c] = quo[c];
      end
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      reps_left <= '0;
      step      <= '0;
    end else begin
      unique case (state)
        B_IDLE: begin
          if (!empty) begin
            reps_left <= job.reps;
            step      <= '0;
            state     <= (job.count == '0) ? B_EMIT : B_DIV;
          end
        end
        B_DIV: begin
          step <= step + STP_W'(1);
          if (step == LAST_STEP) begin
            state <= B_EMIT;
          end
        end
        B_EMIT: begin
          if (load_out) begin
            reps_left <= reps_left - REPS_W'(1);
            if (reps_left == REPS_W'(1)) begin
              state <= B_IDLE;
            end
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

  // restoring divide, one quotient bit per cycle for all three channels
  always_ff @(posedge clk) begin
    if (pop) begin
      is_empty <= (job.count == '0);
      dvs      <= REM_W'(job.count) << (CHAN_W - 1);
      for (int c = 0; c < NCH; c++) begin
        neg[c] <= sum_in[c][ACC_W-1] || (sum_in[c] == '0);
        sat[c] <= ({1'b0, sum_in[c][ACC_W-2:CHAN_W]} >= job.count);
        rem[c] <= sum_in[c][REM_W-1:0];
        quo[c] <= '0;
      end
    end else if (state == B_DIV) begin
      dvs <= dvs >> 1;
      for (int c = 0; c < NCH; c++) begin
        if (rem[c] >= dvs) begin
          rem[c] <= rem[c] - dvs;
          quo[c] <= {quo[c][CHAN_W-2:0], 1'b1};
        end else begin
          quo[c] <= {quo[c][CHAN_W-2:0], 1'b0};
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_red   <= chan_res[0];
      out_green <= chan_res[1];
      out_blue  <= chan_res[2];
      out_empty <= is_empty;
      out_last  <= (reps_left == REPS_W'(1));
    end
  end

  // emit phase always has a repeat left to send
  assert property (@(posedge clk) disable iff (rst) (state == B_EMIT) |-> (reps_left != '0))
    else $error("emit phase entered with no repeats left");
  // an empty marker carries zero channels
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_empty) |-> (out_red == '0 && out_green == '0 && out_blue == '0))
    else $error("empty marker with nonzero channels");

endmodule

>>> rtl/rgb_row_resampler.sv
// ----------------------------------------------------------------------------
// rgb_row_resampler
// Bresenham row scaler for accumulated RGB pixels with box-filter averaging.
// ----------------------------------------------------------------------------
// Scales one row from source_width to target_width pixels. When shrinking,
// the front end takes one source pixel per cycle while the job queue is not
// full and sums it into the current column; when enlarging it holds each
// source pixel while a repeat loop subtracts from the error term once per
// repeat it asks for (one subtract of the repeat loop per cycle). Each
// finished column or repeated pixel is queued for the back end, which runs a
// restoring divide of the channel sums by the sample count (skipped when the
// count is zero) and then emits the pixel once per repeat; it finishes one
// job before it takes the next from the queue.
// Pixels with a zero count come out as empty markers.
// Configuration writes are taken at any time but belong between items.
module rgb_row_resampler #(
  parameter int MAX_WIDTH = rgbr_pkg::MAX_WIDTH_DEF,
  parameter int MAX_RATIO = rgbr_pkg::MAX_RATIO_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  // configuration writes
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [rgbr_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [rgbr_pkg::CFG_W-1:0]         cfg_data,
  // source pixels
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [87:0]                        s_axis_tdata,  // red_sum, green_sum, blue_sum, sample_count
  input  logic [0:0]                         s_axis_tuser,  // row_start
  // resampled pixels
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [23:0]                        m_axis_tdata,  // red_out, green_out, blue_out
  output logic [0:0]                         m_axis_tuser,  // empty_res
  output logic                               m_axis_tlast
);
  import rgbr_pkg::*;

  cfg_t cfg;
  job_t front_job, queue_job;
  logic push, full, pop, empty;
  logic [CHAN_W-1:0] red_out, green_out, blue_out;
  logic empty_res;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.source_width <= CFG_W'(1);
      cfg.target_width <= CFG_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_SOURCE_WIDTH: cfg.source_width <= cfg_data;
        REG_TARGET_WIDTH: cfg.target_width <= cfg_data;
      endcase
    end
  end

  // classification and error term
  rgbr_front #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_RATIO (MAX_RATIO)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .in_valid     (s_axis_tvalid),
    .in_ready     (s_axis_tready),
    .in_red       ($signed(s_axis_tdata[23:0])),
    .in_green     ($signed(s_axis_tdata[47:24])),
    .in_blue      ($signed(s_axis_tdata[71:48])),
    .in_count     (s_axis_tdata[87:72]),
    .in_row_start (s_axis_tuser[0]),
    .job          (front_job),
    .push         (push),
    .full         (full)
  );

  // job queue
  rgbr_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .wr_job (front_job),
    .push   (push),
    .full   (full),
    .rd_job (queue_job),
    .pop    (pop),
    .empty  (empty)
  );

  // averaging and emission
  rgbr_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job       (queue_job),
    .empty     (empty),
    .pop       (pop),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_red   (red_out),
    .out_green (green_out),
    .out_blue  (blue_out),
    .out_empty (empty_res),
    .out_last  (m_axis_tlast)
  );

  assign m_axis_tdata = {blue_out, green_out, red_out};
  assign m_axis_tuser = empty_res;

endmodule
